>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the trace event filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("concurrent assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("concurrent assertion failed");

`endif

>>> src/tefp_pkg.sv
// ---------------------------------------------------------------------------
// Trace event process filter package
// Event classes, opcodes, payload limits and shared types.
// ---------------------------------------------------------------------------
package tefp_pkg;

  localparam logic [2:0] CLS_INFO    = 3'd0;
  localparam logic [2:0] CLS_IMAGE   = 3'd1;
  localparam logic [2:0] CLS_SAMPLE  = 3'd2;
  localparam logic [2:0] CLS_STACK   = 3'd3;
  localparam logic [2:0] CLS_THREAD  = 3'd4;
  localparam logic [2:0] CLS_PROCESS = 3'd5;

  localparam logic [7:0] OP_START     = 8'd1;
  localparam logic [7:0] OP_STOP      = 8'd2;
  localparam logic [7:0] OP_RD_START  = 8'd3;
  localparam logic [7:0] OP_RD_END    = 8'd4;
  localparam logic [7:0] OP_LOAD      = 8'd10;
  localparam logic [7:0] OP_STACKWALK = 8'd32;
  localparam logic [7:0] OP_SAMPLE    = 8'd46;

  localparam logic [7:0] VER_MIN = 8'd1;
  localparam logic [7:0] VER_MAX = 8'd4;

  localparam logic [31:0] PID_IDLE   = 32'd0;
  localparam logic [31:0] PID_SYSTEM = 32'd4;

  localparam logic [15:0] LEN_IMAGE_NARROW  = 16'd12;
  localparam logic [15:0] LEN_IMAGE_WIDE    = 16'd24;
  localparam logic [15:0] LEN_SAMPLE_NARROW = 16'd8;
  localparam logic [15:0] LEN_SAMPLE_WIDE   = 16'd16;
  localparam logic [15:0] LEN_STACK         = 16'd16;
  localparam logic [15:0] LEN_THREAD        = 16'd8;
  localparam logic [15:0] LEN_PROCESS_NARROW = 16'd8;
  localparam logic [15:0] LEN_PROCESS_WIDE   = 16'd16;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  opcode;
    logic [7:0]  version;
    logic        wide_pointers;
    logic [15:0] payload_length;
    logic [31:0] payload_pid;
    logic [31:0] payload_tid;
    logic [31:0] source_pid;
  } event_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } set_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
  } set_status_t;

endpackage

>>> src/tefp_event_if.sv
// ---------------------------------------------------------------------------
// Trace event channel
// Valid/ready channel carrying one trace event header per transfer.
// ---------------------------------------------------------------------------
interface tefp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  opcode;
  logic [7:0]  version;
  logic        wide_pointers;
  logic [15:0] payload_length;
  logic [31:0] payload_pid;
  logic [31:0] payload_tid;
  logic [31:0] source_pid;

  modport source (output valid, action, opcode, version, wide_pointers, payload_length,
                  payload_pid, payload_tid, source_pid, input ready);
  modport sink (input valid, action, opcode, version, wide_pointers, payload_length,
                payload_pid, payload_tid, source_pid, output ready);
endinterface

>>> src/tefp_result_if.sv
// ---------------------------------------------------------------------------
// Filter result channel
// Valid/ready channel carrying the keep decision for one event per transfer.
// ---------------------------------------------------------------------------
interface tefp_result_if;
  logic valid;
  logic ready;
  logic keep;
  logic set_overflow;

  modport source (output valid, keep, set_overflow, input ready);
  modport sink (input valid, keep, set_overflow, output ready);
endinterface

>>> src/tefp_cfg_if.sv
// ---------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the target process id register.
// ---------------------------------------------------------------------------
interface tefp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_pid;

  modport source (output valid, target_pid, input ready);
  modport sink (input valid, target_pid, output ready);
endinterface

>>> src/trace_event_process_filter_core.sv
// ---------------------------------------------------------------------------
// Trace event process filter core
// Keeps the trace events of one target process and tracks its live threads.
// ---------------------------------------------------------------------------
// Event headers enter on the trace channel and one result per event leaves
// on the verdict channel, in order, carrying keep and set_overflow.
// The cfg channel writes the target process id; it is always ready and
// should only be written while no event is in flight.
// An accepted event is held in an input register, where it is classified
// against the thread set; the result register is loaded when the event
// leaves it, together with any insert or remove on the set, and drives
// the verdict channel. Throughput is one event per cycle while the verdict
// is not stalled: the set update from one event is seen by the event
// directly behind it. The rate rests on the combinational parallel
// compare of the thread id against every slot of the set.
// When the verdict is stalled, the result register holds and the input
// register keeps one more event, after which trace ready drops.
// Reset clears the target process id to zero and empties the thread set.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module trace_event_process_filter_core
  import tefp_pkg::*;
#(
  parameter int THREAD_SLOTS = 64
) (
  input logic          clk,
  input logic          rst,
  tefp_event_if.sink   trace,
  tefp_result_if.source verdict,
  tefp_cfg_if.sink     cfg
);

  logic [31:0] target_pid;
  logic        stage_valid;
  event_t      stage;
  logic        advance;
  logic        out_valid;
  logic        out_keep;
  logic        out_overflow;
  set_cmd_t    cmd;
  set_status_t status;
  logic        keep_next;
  logic        overflow_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_pid <= '0;
    end else if (cfg.valid) begin
      target_pid <= cfg.target_pid;
    end
  end

  assign advance     = stage_valid && (!out_valid || verdict.ready);
  assign trace.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (trace.ready) begin
      stage_valid <= trace.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (trace.valid && trace.ready) begin
      stage.action         <= trace.action;
      stage.opcode         <= trace.opcode;
      stage.version        <= trace.version;
      stage.wide_pointers  <= trace.wide_pointers;
      stage.payload_length <= trace.payload_length;
      stage.payload_pid    <= trace.payload_pid;
      stage.payload_tid    <= trace.payload_tid;
      stage.source_pid     <= trace.source_pid;
    end
  end

  tefp_thread_set #(
    .THREAD_SLOTS(THREAD_SLOTS)
  ) u_set (
    .clk    (clk),
    .rst    (rst),
    .tid    (stage.payload_tid),
    .update (advance),
    .cmd    (cmd),
    .status (status)
  );

  tefp_classify u_classify (
    .evt          (stage),
    .target_pid   (target_pid),
    .status       (status),
    .cmd          (cmd),
    .keep         (keep_next),
    .set_overflow (overflow_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_keep     <= keep_next;
      out_overflow <= overflow_next;
    end
  end

  assign verdict.valid        = out_valid;
  assign verdict.keep         = out_keep;
  assign verdict.set_overflow = out_overflow;

  `ASSERT_IMPLY(a_overflow_kept, clk, rst, out_valid && out_overflow, out_keep)
  `ASSERT_NEXT(a_advance_fills, clk, rst, advance, out_valid)
  `ASSERT_NEXT(a_verdict_hold, clk, rst, out_valid && !verdict.ready,
               out_valid && $stable(out_keep) && $stable(out_overflow))

endmodule

>>> src/tefp_thread_set.sv
// ---------------------------------------------------------------------------
// Thread id set
// Content-addressed set of live thread ids with lowest-free-slot insertion.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tefp_thread_set
  import tefp_pkg::*;
#(
  parameter int THREAD_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] tid,
  input  logic        update,
  input  set_cmd_t    cmd,
  output set_status_t status
);

  logic [THREAD_SLOTS-1:0] valid;
  logic [31:0]             ids [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] match;
  logic [THREAD_SLOTS-1:0] free;
  logic [THREAD_SLOTS-1:0] first_free;

  always_comb begin
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      match[i] = valid[i] && (ids[i] == tid);
    end
  end

  assign free       = ~valid;
  assign first_free = free & (~free + THREAD_SLOTS'(1));
  assign status.hit  = |match;
  assign status.full = &valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (update) begin
      if (cmd.insert) begin
        valid <= valid | first_free;
      end else if (cmd.remove) begin
        valid <= valid & ~match;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      if (update && cmd.insert && first_free[i]) begin
        ids[i] <= tid;
      end
    end
  end

  `ASSERT_IMPLY(a_no_duplicate, clk, rst, 1'b1, $onehot0(match))
  `ASSERT_NEXT(a_insert_grows, clk, rst, update && cmd.insert,
               $countones(valid) == $past($countones(valid)) + 1)
  `ASSERT_NEXT(a_remove_shrinks, clk, rst, update && cmd.remove && status.hit,
               $countones(valid) + 1 == $past($countones(valid)))

endmodule

>>> src/tefp_classify.sv
// ---------------------------------------------------------------------------
// Event classifier
// Per-class opcode, version and length checks, keep decision and set commands.
// ---------------------------------------------------------------------------
module tefp_classify
  import tefp_pkg::*;
(
  input  event_t      evt,
  input  logic [31:0] target_pid,
  input  set_status_t status,
  output set_cmd_t    cmd,
  output logic        keep,
  output logic        set_overflow
);

  logic lifecycle;
  logic ppid_match;
  logic thread_ok;
  logic starts;
  logic class_keep;

  assign lifecycle = (evt.opcode == OP_START) || (evt.opcode == OP_STOP) ||
                     (evt.opcode == OP_RD_START) || (evt.opcode == OP_RD_END);
  assign ppid_match = evt.payload_pid == target_pid;
  assign thread_ok  = (evt.action == CLS_THREAD) && lifecycle &&
                      (evt.payload_length >= LEN_THREAD) && ppid_match;
  assign starts     = (evt.opcode == OP_START) || (evt.opcode == OP_RD_START);

  always_comb begin
    class_keep = 1'b0;
    case (evt.action)
      CLS_INFO: begin
        class_keep = 1'b1;
      end
      CLS_IMAGE: begin
        class_keep = ((evt.opcode == OP_LOAD) || (evt.opcode == OP_STOP) ||
                      (evt.opcode == OP_RD_START) || (evt.opcode == OP_RD_END)) &&
                     (evt.payload_length >= (evt.wide_pointers ? LEN_IMAGE_WIDE
                                                               : LEN_IMAGE_NARROW)) &&
                     ((evt.payload_pid == PID_IDLE) || (evt.payload_pid == PID_SYSTEM) ||
                      ppid_match);
      end
      CLS_SAMPLE: begin
        class_keep = (evt.opcode == OP_SAMPLE) &&
                     (evt.payload_length >= (evt.wide_pointers ? LEN_SAMPLE_WIDE
                                                               : LEN_SAMPLE_NARROW)) &&
                     status.hit;
      end
      CLS_STACK: begin
        class_keep = (evt.opcode == OP_STACKWALK) && (evt.payload_length >= LEN_STACK) &&
                     ppid_match;
      end
      CLS_THREAD: begin
        class_keep = thread_ok;
      end
      CLS_PROCESS: begin
        class_keep = lifecycle && (evt.version >= VER_MIN) && (evt.version <= VER_MAX) &&
                     (evt.payload_length >= (evt.wide_pointers ? LEN_PROCESS_WIDE
                                                               : LEN_PROCESS_NARROW)) &&
                     ppid_match;
      end
      default: begin
        class_keep = 1'b0;
      end
    endcase
  end

  assign cmd.insert   = thread_ok && starts && !status.hit && !status.full;
  assign cmd.remove   = thread_ok && (evt.opcode == OP_STOP);
  assign set_overflow = thread_ok && starts && !status.hit && status.full;
  assign keep         = class_keep || (evt.source_pid == target_pid);

endmodule

>>> verif/tefp_filter_checker.sv
// ---------------------------------------------------------------------------
// Trace event filter checker
// Watches the trace, cfg and verdict channels of the filter core, predicts
// the keep decision and the set overflow flag of every accepted event from a
// private copy of the target process id and the live thread set, and
// compares each verdict transfer with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module tefp_filter_checker
  import tefp_pkg::*;
#(
  parameter int THREAD_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  tefp_event_if       trace,
  tefp_result_if      verdict,
  tefp_cfg_if         cfg,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned verdicts,
  output int unsigned kept,
  output int unsigned overflows,
  output int unsigned settings
);

  typedef struct packed {
    logic keep;
    logic set_overflow;
  } verdict_t;

  logic [31:0] watched_pid;
  logic [31:0] live_tid  [THREAD_SLOTS];
  logic        live_used [THREAD_SLOTS];
  verdict_t    due_verdicts[$];
  int unsigned err_n, verdict_n, kept_n, ovf_n, setting_n;

  function automatic int tid_slot(input logic [31:0] tid);
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      if (live_used[i] && live_tid[i] == tid) return i;
    end
    return -1;
  endfunction

  function automatic logic add_thread(input logic [31:0] tid);
    if (tid_slot(tid) >= 0) return 1'b0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      if (!live_used[i]) begin
        live_used[i] = 1'b1;
        live_tid[i]  = tid;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic is_lifecycle(input logic [7:0] op);
    return op == OP_START || op == OP_STOP || op == OP_RD_START || op == OP_RD_END;
  endfunction

  function automatic verdict_t filter_event(input event_t ev);
    verdict_t    v;
    logic [15:0] need;
    int          slot;
    v = '0;
    case (ev.action)
      CLS_INFO: begin
        v.keep = 1'b1;
      end
      CLS_IMAGE: begin
        need = ev.wide_pointers ? LEN_IMAGE_WIDE : LEN_IMAGE_NARROW;
        if ((ev.opcode == OP_LOAD || ev.opcode == OP_STOP || ev.opcode == OP_RD_START ||
             ev.opcode == OP_RD_END) && ev.payload_length >= need)
          v.keep = ev.payload_pid == PID_IDLE || ev.payload_pid == PID_SYSTEM ||
                   ev.payload_pid == watched_pid;
      end
      CLS_SAMPLE: begin
        need = ev.wide_pointers ? LEN_SAMPLE_WIDE : LEN_SAMPLE_NARROW;
        if (ev.opcode == OP_SAMPLE && ev.payload_length >= need)
          v.keep = tid_slot(ev.payload_tid) >= 0;
      end
      CLS_STACK: begin
        if (ev.opcode == OP_STACKWALK && ev.payload_length >= LEN_STACK)
          v.keep = ev.payload_pid == watched_pid;
      end
      CLS_THREAD: begin
        if (is_lifecycle(ev.opcode) && ev.payload_length >= LEN_THREAD &&
            ev.payload_pid == watched_pid) begin
          v.keep = 1'b1;
          if (ev.opcode == OP_START || ev.opcode == OP_RD_START) begin
            v.set_overflow = add_thread(ev.payload_tid);
          end else if (ev.opcode == OP_STOP) begin
            slot = tid_slot(ev.payload_tid);
            if (slot >= 0) live_used[slot] = 1'b0;
          end
        end
      end
      CLS_PROCESS: begin
        need = ev.wide_pointers ? LEN_PROCESS_WIDE : LEN_PROCESS_NARROW;
        if (is_lifecycle(ev.opcode) && ev.version >= VER_MIN && ev.version <= VER_MAX &&
            ev.payload_length >= need)
          v.keep = ev.payload_pid == watched_pid;
      end
      default: begin
      end
    endcase
    if (!v.keep && ev.source_pid == watched_pid) v.keep = 1'b1;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    event_t   ev;
    if (rst) begin
      watched_pid = '0;
      for (int i = 0; i < THREAD_SLOTS; i++) live_used[i] = 1'b0;
      due_verdicts.delete();
      err_n     = 0;
      verdict_n = 0;
      kept_n    = 0;
      ovf_n     = 0;
      setting_n = 0;
    end else begin
      if (verdict.valid && verdict.ready) begin
        got.keep         = verdict.keep;
        got.set_overflow = verdict.set_overflow;
        verdict_n++;
        if (due_verdicts.size() == 0) begin
          err_n++;
          $display("%0t: verdict transfer with no event outstanding: %s %0b %0b",
                   $time, "expected none, got keep and set_overflow",
                   got.keep, got.set_overflow);
        end else begin
          want = due_verdicts.pop_front();
          if (got.keep !== want.keep) begin
            err_n++;
            $display("%0t: keep mismatch: expected %0b, got %0b", $time, want.keep, got.keep);
          end
          if (got.set_overflow !== want.set_overflow) begin
            err_n++;
            $display("%0t: set_overflow mismatch: expected %0b, got %0b",
                     $time, want.set_overflow, got.set_overflow);
          end
          if (want.keep) kept_n++;
          if (want.set_overflow) ovf_n++;
        end
      end
      if (trace.valid && trace.ready) begin
        ev.action         = trace.action;
        ev.opcode         = trace.opcode;
        ev.version        = trace.version;
        ev.wide_pointers  = trace.wide_pointers;
        ev.payload_length = trace.payload_length;
        ev.payload_pid    = trace.payload_pid;
        ev.payload_tid    = trace.payload_tid;
        ev.source_pid     = trace.source_pid;
        due_verdicts.push_back(filter_event(ev));
      end
      if (cfg.valid && cfg.ready) begin
        watched_pid = cfg.target_pid;
        setting_n++;
      end
    end
    errors    <= err_n;
    pending   <= due_verdicts.size();
    verdicts  <= verdict_n;
    kept      <= kept_n;
    overflows <= ovf_n;
    settings  <= setting_n;
  end

endmodule

>>> verif/tb_trace_event_process_filter_core.sv
// ---------------------------------------------------------------------------
// Trace event process filter testbench
// Drives directed and random trace events through the filter core under
// several target process ids, with random idling on both channels, two
// thread set fill bursts and two long result stalls; the checker beside the
// core predicts and compares every verdict.
// ---------------------------------------------------------------------------
module tb_trace_event_process_filter_core;
  import tefp_pkg::*;

  localparam int          SLOTS       = 64;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 225;
  localparam int          POOL        = 80;
  localparam int          LONG_HOLD   = 120;
  localparam int          SETTLE      = 6;
  localparam int unsigned CYCLE_LIMIT = 600000;

  localparam logic [2:0]  CLS_UNKNOWN = 3'd6;
  localparam logic [2:0]  CLS_SPARE   = 3'd7;
  localparam logic [7:0]  OP_BOGUS    = 8'd11;
  localparam logic [31:0] D_PID       = 32'h0000_1234;
  localparam logic [31:0] O_PID       = 32'h0000_0777;
  localparam logic [31:0] T_A         = 32'h8000_00A5;
  localparam logic [31:0] T_B         = 32'h0000_0B0B;

  logic clk;
  logic rst;

  tefp_event_if  trace_ch ();
  tefp_result_if verdict_ch ();
  tefp_cfg_if    cfg_ch ();

  int unsigned fail_count, pending, verdicts, kept, overflows, settings;
  int unsigned sent;
  logic [31:0] target;
  logic [31:0] tid_pool [POOL];
  logic [31:0] phase_pid [PHASES];
  bit          calm;
  bit          want_hold;

  trace_event_process_filter_core #(.THREAD_SLOTS(SLOTS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .trace   (trace_ch),
    .verdict (verdict_ch),
    .cfg     (cfg_ch)
  );

  tefp_filter_checker #(.THREAD_SLOTS(SLOTS)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .trace     (trace_ch),
    .verdict   (verdict_ch),
    .cfg       (cfg_ch),
    .errors    (fail_count),
    .pending   (pending),
    .verdicts  (verdicts),
    .kept      (kept),
    .overflows (overflows),
    .settings  (settings)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic event_t hdr(input logic [2:0] action, input logic [7:0] opcode,
                                 input logic [7:0] version, input logic wide,
                                 input logic [15:0] len, input logic [31:0] ppid,
                                 input logic [31:0] ptid, input logic [31:0] spid);
    event_t ev;
    ev.action         = action;
    ev.opcode         = opcode;
    ev.version        = version;
    ev.wide_pointers  = wide;
    ev.payload_length = len;
    ev.payload_pid    = ppid;
    ev.payload_tid    = ptid;
    ev.source_pid     = spid;
    return ev;
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(24, 600));
    if (r < 90) begin
      case ($urandom_range(0, 8))
        0: return 16'd0;
        1: return 16'd7;
        2: return 16'd8;
        3: return 16'd11;
        4: return 16'd12;
        5: return 16'd15;
        6: return 16'd16;
        7: return 16'd23;
        default: return 16'd24;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_pid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return target;
    if (r < 65) return PID_IDLE;
    if (r < 75) return PID_SYSTEM;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_tid(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return tid_pool[$urandom_range(0, POOL - 1)];
    return $urandom;
  endfunction

  function automatic event_t random_event();
    event_t ev;
    int     kind;
    int     r;
    ev = hdr(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 1'($urandom),
             16'($urandom), $urandom, $urandom, $urandom);
    kind = $urandom_range(0, 99);
    if (kind < 28) begin
      r = $urandom_range(0, 99);
      ev.action = CLS_THREAD;
      if (r < 40) ev.opcode = OP_START;
      else if (r < 55) ev.opcode = OP_RD_START;
      else if (r < 85) ev.opcode = OP_STOP;
      else if (r < 95) ev.opcode = OP_RD_END;
      if ($urandom_range(0, 99) < 88) ev.payload_pid = target;
      ev.payload_tid    = pick_tid(90);
      ev.payload_length = pick_length();
    end else if (kind < 50) begin
      ev.action = CLS_SAMPLE;
      if ($urandom_range(0, 99) < 92) ev.opcode = OP_SAMPLE;
      ev.payload_tid    = pick_tid(75);
      ev.payload_length = pick_length();
    end else if (kind < 60) begin
      ev.action = CLS_IMAGE;
      case ($urandom_range(0, 4))
        0: ev.opcode = OP_LOAD;
        1: ev.opcode = OP_STOP;
        2: ev.opcode = OP_RD_START;
        3: ev.opcode = OP_RD_END;
        default: ;
      endcase
      ev.payload_pid    = pick_pid();
      ev.payload_length = pick_length();
    end else if (kind < 70) begin
      ev.action = CLS_STACK;
      if ($urandom_range(0, 99) < 90) ev.opcode = OP_STACKWALK;
      ev.payload_pid    = pick_pid();
      ev.payload_length = pick_length();
    end else if (kind < 80) begin
      ev.action = CLS_PROCESS;
      if ($urandom_range(0, 99) < 90) ev.opcode = 8'($urandom_range(1, 4));
      if ($urandom_range(0, 99) < 85) ev.version = 8'($urandom_range(0, 6));
      ev.payload_pid    = pick_pid();
      ev.payload_length = pick_length();
    end else if (kind < 84) begin
      ev.action = CLS_INFO;
    end
    if ($urandom_range(0, 99) < 15) ev.source_pid = target;
    return ev;
  endfunction

  task automatic send_event(input event_t ev);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      trace_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    trace_ch.valid          <= 1'b1;
    trace_ch.action         <= ev.action;
    trace_ch.opcode         <= ev.opcode;
    trace_ch.version        <= ev.version;
    trace_ch.wide_pointers  <= ev.wide_pointers;
    trace_ch.payload_length <= ev.payload_length;
    trace_ch.payload_pid    <= ev.payload_pid;
    trace_ch.payload_tid    <= ev.payload_tid;
    trace_ch.source_pid     <= ev.source_pid;
    do @(posedge clk); while (!trace_ch.ready);
    sent++;
  endtask

  task automatic drain();
    trace_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_target(input logic [31:0] pid);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.target_pid <= pid;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    target = pid;
  endtask

  task automatic fill_thread_set();
    for (int i = 0; i < POOL; i++) begin
      tid_pool[i] = $urandom;
      send_event(hdr(CLS_THREAD, OP_START, 8'($urandom), 1'($urandom),
                     16'($urandom_range(8, 64)), target, tid_pool[i], $urandom));
    end
  endtask

  initial begin
    int gap;
    verdict_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        verdict_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        verdict_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        gap = idle_len();
        if (gap > 0) begin
          verdict_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run stopped after %0d cycles with %0d verdicts outstanding",
             $time, cycles, pending);
    $display("tb_trace_event_process_filter_core: done, errors");
    $finish;
  end

  initial begin
    rst                     <= 1'b1;
    trace_ch.valid          <= 1'b0;
    trace_ch.action         <= '0;
    trace_ch.opcode         <= '0;
    trace_ch.version        <= '0;
    trace_ch.wide_pointers  <= 1'b0;
    trace_ch.payload_length <= '0;
    trace_ch.payload_pid    <= '0;
    trace_ch.payload_tid    <= '0;
    trace_ch.source_pid     <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.target_pid       <= '0;
    calm      = 1'b0;
    want_hold = 1'b0;
    sent      = 0;
    target    = '0;
    foreach (tid_pool[i]) tid_pool[i] = $urandom;
    phase_pid = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, PID_SYSTEM, $urandom, $urandom};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_target(D_PID);
    send_event(hdr(CLS_INFO, 8'd0, 8'd0, 1'b0, 16'd0, 32'd0, 32'd0, O_PID));
    send_event(hdr(CLS_IMAGE, OP_LOAD, 8'd0, 1'b1, LEN_IMAGE_WIDE, PID_IDLE, 32'd0, O_PID));
    send_event(hdr(CLS_IMAGE, OP_LOAD, 8'd0, 1'b1, LEN_IMAGE_WIDE - 16'd1, PID_IDLE, 32'd0,
                   O_PID));
    send_event(hdr(CLS_IMAGE, OP_STOP, 8'd0, 1'b0, LEN_IMAGE_NARROW, PID_SYSTEM, 32'd0, O_PID));
    send_event(hdr(CLS_IMAGE, OP_RD_END, 8'd0, 1'b0, LEN_IMAGE_NARROW, O_PID, 32'd0, O_PID));
    send_event(hdr(CLS_IMAGE, OP_BOGUS, 8'd0, 1'b0, 16'hFFFF, D_PID, 32'd0, O_PID));
    send_event(hdr(CLS_STACK, OP_STACKWALK, 8'd0, 1'b0, LEN_STACK, D_PID, 32'd0, O_PID));
    send_event(hdr(CLS_STACK, OP_STACKWALK, 8'd0, 1'b1, LEN_STACK - 16'd1, D_PID, 32'd0, O_PID));
    send_event(hdr(CLS_THREAD, OP_START, 8'd0, 1'b0, LEN_THREAD, D_PID, T_A, O_PID));
    send_event(hdr(CLS_THREAD, OP_RD_START, 8'd0, 1'b1, LEN_THREAD, D_PID, T_A, O_PID));
    send_event(hdr(CLS_SAMPLE, OP_SAMPLE, 8'd0, 1'b0, LEN_SAMPLE_NARROW, 32'd0, T_A, O_PID));
    send_event(hdr(CLS_SAMPLE, OP_SAMPLE, 8'd0, 1'b1, LEN_SAMPLE_WIDE - 16'd1, 32'd0, T_A,
                   O_PID));
    send_event(hdr(CLS_THREAD, OP_RD_END, 8'd0, 1'b0, LEN_THREAD, D_PID, T_A, O_PID));
    send_event(hdr(CLS_THREAD, OP_STOP, 8'd0, 1'b0, LEN_THREAD, D_PID, T_B, O_PID));
    send_event(hdr(CLS_THREAD, OP_STOP, 8'd0, 1'b0, LEN_THREAD, D_PID, T_A, O_PID));
    send_event(hdr(CLS_SAMPLE, OP_SAMPLE, 8'd0, 1'b1, LEN_SAMPLE_WIDE, 32'd0, T_A, O_PID));
    send_event(hdr(CLS_THREAD, OP_START, 8'd0, 1'b0, LEN_THREAD - 16'd1, D_PID, T_B, O_PID));
    send_event(hdr(CLS_SAMPLE, OP_SAMPLE, 8'd0, 1'b0, LEN_SAMPLE_NARROW, 32'd0, T_B, O_PID));
    send_event(hdr(CLS_THREAD, OP_START, 8'd0, 1'b0, LEN_THREAD, O_PID, T_B, O_PID));
    send_event(hdr(CLS_PROCESS, OP_START, VER_MIN, 1'b0, LEN_PROCESS_NARROW, D_PID, 32'd0,
                   O_PID));
    send_event(hdr(CLS_PROCESS, OP_RD_END, VER_MAX, 1'b1, LEN_PROCESS_WIDE, D_PID, 32'd0,
                   O_PID));
    send_event(hdr(CLS_PROCESS, OP_STOP, VER_MAX + 8'd1, 1'b0, LEN_PROCESS_NARROW, D_PID, 32'd0,
                   O_PID));
    send_event(hdr(CLS_PROCESS, OP_RD_START, VER_MIN - 8'd1, 1'b1, LEN_PROCESS_WIDE - 16'd1,
                   D_PID, 32'd0, O_PID));
    send_event(hdr(CLS_UNKNOWN, OP_START, VER_MIN, 1'b0, 16'hFFFF, D_PID, 32'd0, D_PID));
    send_event(hdr(CLS_SPARE, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_target(phase_pid[p]);
      calm = (p == 3);
      if (p == 2 || p == 5) want_hold = 1'b1;
      if (p == 0 || p == 4) fill_thread_set();
      repeat (PHASE_ITEMS) send_event(random_event());
    end
    drain();

    $display("Sent %0d events under %0d target settings; %0d verdicts checked, %0d kept.",
             sent, settings, verdicts, kept);
    $display("Thread set inserts dropped when full: %0d, with two long result stalls.",
             overflows);
    if (fail_count == 0) begin
      $display("tb_trace_event_process_filter_core: done, clean");
    end else begin
      $display("tb_trace_event_process_filter_core: done, errors");
    end
    $finish;
  end

endmodule
